### sv/ksb_pkg.sv
// ksb_pkg: shared types and constants for the k-stacks shared buffer unit
// command and result payloads, pointer type, opcode and status codes
// no dependencies

package ksb_pkg;

    localparam int PTR_W = 7;

    typedef logic [PTR_W-1:0] ptr_t;

    localparam ptr_t NIL = 7'd127;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_SHOW = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADID = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         stack_id;
        logic signed [31:0] push_value;
    } ksb_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
        logic               last;
    } ksb_out_t;

    // one access of the link store: a read and a write in the same cycle
    typedef struct packed {
        logic rd_en;
        ptr_t rd_ptr;
        logic wr_en;
        ptr_t wr_ptr;
        ptr_t wr_data;
    } link_req_t;

endpackage

### sv/ksb_link_mem.sv
// ksb_link_mem: link store, one next pointer per buffer entry
// synchronous read; unwritten entries read as i+1 / NIL
// depends on ksb_pkg

module ksb_link_mem
    import ksb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  link_req_t req,
    output ptr_t      rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ptr_t             mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    ptr_t             rd_data_reg;
    logic [AW-1:0]    wa;
    logic [AW-1:0]    ra;

    // chain at reset: each entry points at the next one, the final entry at null
    function automatic ptr_t init_link(input logic [AW-1:0] a);
        ptr_t r;
        if (a == AW'(DEPTH - 1))
            r = NIL;
        else
            r = PTR_W'(a) + ptr_t'(1);
        return r;
    endfunction

    assign wa = req.wr_ptr[AW-1:0];
    assign ra = req.rd_ptr[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[wa] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wa] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= vld_reg[ra] ? mem[ra] : init_link(ra);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/k_stacks_shared_buffer_unit.sv
// k_stacks_shared_buffer_unit: several stacks sharing one data store through a free list
// top level: command sequencer, top pointer store, data store
// depends on ksb_pkg and ksb_link_mem

// usage
//   command channel: drive cmd and raise start; a transfer happens at a rising edge
//   with start high and busy low. opcode push / pop / display addresses one stack.
//   result channel: each result sits on result for exactly one cycle with
//   result_strobe high; last marks the final result of a command. the receiver
//   cannot stall, so no result is ever held back.
//   config: cfg_we / cfg_data write stack_count; user must write only while the unit is idle, not enforced
// sequence per command (result strobe is registered from the deciding cycle)
//   unused opcode: no result, busy never rises
//   invalid stack: result decided while idle, busy never rises
//   push / empty or full stack: top pointer and link read, then result or update
//   pop: top pointer read, link and data read, then write back
//   display: top pointer read, then one link store read and one result per element
//   the single read port of the link store sets the per-element walk rate
// reset
//   all stacks empty, free list chained 0..DEPTH-1, stack_count = 8;
//   valid bits stand in for the reset contents, so no clearing pass is needed

module k_stacks_shared_buffer_unit
    import ksb_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int MAX_STACKS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  ksb_in_t    cmd,
    output logic       result_strobe,
    output ksb_out_t   result,
    input  logic       cfg_we,
    input  logic [3:0] cfg_data
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // stack_id is 3 bits, so at most eight top pointers are reachable
    localparam int TOP_N = (MAX_STACKS < 8) ? MAX_STACKS : 8;
    localparam int TAW   = (TOP_N > 1) ? $clog2(TOP_N) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_WALK = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    ksb_in_t       cmd_reg;
    logic [3:0]    stack_count_reg;
    ptr_t          free_head_reg, free_head_next;
    ptr_t          slot_reg, slot_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    ksb_out_t      result_reg, result_next;
    logic          strobe_reg, strobe_next;

    // top pointer store with valid bits (unwritten reads as null)
    ptr_t             top_mem [TOP_N];
    logic [TOP_N-1:0] top_vld_reg;
    ptr_t             top_rd_reg;
    logic             top_re;
    logic [TAW-1:0]   top_ra;
    logic             top_we;
    ptr_t             top_wd;
    logic [TAW-1:0]   top_wa;

    // data store, contents undefined until pushed
    logic [31:0]   data_mem [DEPTH];
    logic [31:0]   data_rd_reg;
    logic          data_re;
    ptr_t          data_ra;
    logic          data_we;

    link_req_t     link_req;
    ptr_t          link_rd;

    logic          accept;
    logic          bad_id;
    ptr_t          link_nxt;
    logic          walk_fin;

    function automatic logic is_null(input ptr_t p);
        return 32'(p) >= DEPTH;
    endfunction

    function automatic ptr_t norm(input ptr_t p);
        return is_null(p) ? NIL : p;
    endfunction

    ksb_link_mem #(
        .DEPTH (DEPTH)
    ) u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_data (link_rd)
    );

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && (state_reg == S_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    assign bad_id   = ({1'b0, cmd.stack_id} >= stack_count_reg)
                   || (32'(cmd.stack_id) >= MAX_STACKS);
    assign link_nxt = norm(link_rd);
    assign walk_fin = is_null(link_rd) || (cnt_reg == AW'(DEPTH - 1));
    assign top_wa   = cmd_reg.stack_id[TAW-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        strobe_next    = 1'b0;
        top_re         = 1'b0;
        top_ra         = cmd.stack_id[TAW-1:0];
        top_we         = 1'b0;
        top_wd         = NIL;
        data_re        = 1'b0;
        data_ra        = slot_reg;
        data_we        = 1'b0;
        link_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // prefetch the top pointer and the free head's link
                top_re          = 1'b1;
                link_req.rd_en  = !is_null(free_head_reg);
                link_req.rd_ptr = free_head_reg;
                if (start && cmd.opcode != OP_NONE)
                begin
                    if (bad_id)
                    begin
                        result_next = '{status: ST_BADID, value: '0, last: 1'b1};
                        strobe_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                if (cmd_reg.opcode == OP_PUSH)
                begin
                    strobe_next = 1'b1;
                    if (is_null(free_head_reg))
                    begin
                        result_next = '{status: ST_FULL, value: '0, last: 1'b1};
                    end
                    else
                    begin
                        result_next      = '{status: ST_OK, value: '0, last: 1'b1};
                        free_head_next   = link_nxt;
                        link_req.wr_en   = 1'b1;
                        link_req.wr_ptr  = free_head_reg;
                        link_req.wr_data = norm(top_rd_reg);
                        top_we           = 1'b1;
                        top_wd           = free_head_reg;
                        data_we          = 1'b1;
                        data_ra          = free_head_reg;
                    end
                end
                else if (is_null(top_rd_reg))
                begin
                    result_next = '{status: ST_EMPTY, value: '0, last: 1'b1};
                    strobe_next = 1'b1;
                end
                else
                begin
                    // fetch the top element and its link
                    slot_next       = top_rd_reg;
                    cnt_next        = '0;
                    link_req.rd_en  = 1'b1;
                    link_req.rd_ptr = top_rd_reg;
                    data_re         = 1'b1;
                    data_ra         = top_rd_reg;
                    state_next      = (cmd_reg.opcode == OP_POP) ? S_POP : S_WALK;
                end
            end

            S_POP:
            begin
                result_next      = '{status: ST_OK, value: $signed(data_rd_reg), last: 1'b1};
                strobe_next      = 1'b1;
                top_we           = 1'b1;
                top_wd           = link_nxt;
                link_req.wr_en   = 1'b1;
                link_req.wr_ptr  = slot_reg;
                link_req.wr_data = norm(free_head_reg);
                free_head_next   = slot_reg;
                state_next       = S_IDLE;
            end

            S_WALK:
            begin
                result_next = '{status: ST_OK, value: $signed(data_rd_reg), last: walk_fin};
                strobe_next = 1'b1;
                if (walk_fin)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next       = link_nxt;
                    cnt_next        = cnt_reg + AW'(1);
                    link_req.rd_en  = 1'b1;
                    link_req.rd_ptr = link_nxt;
                    data_re         = 1'b1;
                    data_ra         = link_nxt;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stack_count_reg <= 4'd8;
            free_head_reg   <= '0;
            strobe_reg      <= 1'b0;
            top_vld_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            strobe_reg    <= strobe_next;
            if (cfg_we)
            begin
                stack_count_reg <= cfg_data;
            end
            if (top_we)
            begin
                top_vld_reg[top_wa] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        slot_reg   <= slot_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    // top pointer store
    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_wa] <= top_wd;
        end
        if (top_re)
        begin
            top_rd_reg <= top_vld_reg[top_ra] ? top_mem[top_ra] : NIL;
        end
    end

    // data store
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_ra[AW-1:0]] <= cmd_reg.push_value;
        end
        if (data_re)
        begin
            data_rd_reg <= data_mem[data_ra[AW-1:0]];
        end
    end

endmodule
